/* hw/rtl/swa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swa_pkg;

  localparam int SLOTS     = 256;
  localparam int ADDR_W    = 8;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 9;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int GROUP_W   = 16;
  localparam int GROUPS    = SLOTS / GROUP_W;
  localparam int GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int GRP_BIT_W = $clog2(GROUP_W);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PICK,
    ST_RESP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic pick;
  } swa_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    cmd_t req_cmd;
  } swa_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/swa_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface swa_req_if;
  import swa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [ADDR_W-1:0]        slot_addr;
  logic signed [WORD_W-1:0] word_in;

  modport source (output valid, output cmd, output slot_addr, output word_in, input ready);
  modport sink (input valid, input cmd, input slot_addr, input word_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/swa_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface swa_rsp_if;
  import swa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] word_out;
  logic [ADDR_W-1:0]        slot_out;
  logic                     status;
  logic [CNT_W-1:0]         free_slots;

  modport source (output valid, output word_out, output slot_out, output status,
                  output free_slots, input ready);
  modport sink (input valid, input word_out, input slot_out, input status,
                input free_slots, output ready);
endinterface

`default_nettype wire

/* hw/rtl/slot_allocating_word_store.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                                   Beat
// req      in   cmd, slot_addr, word_in                  valid & ready
// rsp      out  word_out, slot_out, status, free_slots   valid & ready
//
// One request at a time. Read and write pass from IDLE through EXEC to RESP,
// where the beat is given; a free gives no beat and goes from EXEC back to
// IDLE. Alloc adds the PICK state between EXEC and RESP for the two-step
// group/bit search over the allocation bitmap. The response beat holds until
// taken, and req stays not ready meanwhile, so a stall adds to the item time.
// Synchronous reset clears the bitmap and sets the free count to the slot count.

module slot_allocating_word_store (
  input logic       clk,
  input logic       rst,
  swa_req_if.sink   req,
  swa_rsp_if.source rsp
);
  import swa_pkg::*;

  swa_ctl_t  ctl;
  swa_stat_t stat;

  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  swa_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .cmd        (req.cmd),
    .slot_addr  (req.slot_addr),
    .word_in    (req.word_in),
    .word_out   (rsp.word_out),
    .slot_out   (rsp.slot_out),
    .status     (rsp.status),
    .free_slots (rsp.free_slots)
  );

endmodule

`default_nettype wire

/* hw/rtl/swa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module swa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  swa_pkg::swa_stat_t stat,
  output swa_pkg::swa_ctl_t  ctl
);
  import swa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (stat.req_cmd)
          CMD_ALLOC: state_next = ST_PICK;
          CMD_FREE:  state_next = ST_IDLE;
          default:   state_next = ST_RESP;
        endcase
      end
      ST_PICK: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    ctl.pick    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
      end
      ST_PICK: begin
        ctl.pick = 1'b1;
      end
      ST_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/swa_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module swa_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  swa_pkg::swa_ctl_t                 ctl,
  output swa_pkg::swa_stat_t                stat,
  input  logic [1:0]                        cmd,
  input  logic [swa_pkg::ADDR_W-1:0]        slot_addr,
  input  logic signed [swa_pkg::WORD_W-1:0] word_in,
  output logic signed [swa_pkg::WORD_W-1:0] word_out,
  output logic [swa_pkg::ADDR_W-1:0]        slot_out,
  output logic                              status,
  output logic [swa_pkg::CNT_W-1:0]         free_slots
);
  import swa_pkg::*;

  cmd_t              req_cmd;
  logic [ADDR_W-1:0] req_addr;
  logic [WORD_W-1:0] req_word;

  logic [SLOTS-1:0]  used_map;
  logic [CNT_W-1:0]  free_count;

  logic [WORD_W-1:0] word_store [SLOTS];
  logic [WORD_W-1:0] mem_q;

  logic [GRP_IDX_W-1:0] grp_sel;
  logic                 none_free;

  logic [WORD_W-1:0] res_word;
  logic [ADDR_W-1:0] res_slot;
  logic              res_status;
  logic [CNT_W-1:0]  res_free;
  logic              res_from_mem;
  logic              res_used;

  logic [SLOT_W-1:0]    req_idx;
  logic                 in_range;
  logic [GROUPS-1:0]    group_full;
  logic [GRP_IDX_W-1:0] first_grp;
  logic [GROUP_W-1:0]   grp_bits;
  logic [GRP_BIT_W-1:0] first_bit;
  logic [SLOT_W-1:0]    alloc_idx;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;

  assign stat.req_cmd = req_cmd;
  assign req_idx      = req_addr[SLOT_W-1:0];
  assign in_range     = (32'(req_addr) < SLOTS);

  // Two-level search: first a group with a clear bit, then the bit in it.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_full[g] = &used_map[g*GROUP_W +: GROUP_W];
    end
    first_grp = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (!group_full[g]) first_grp = GRP_IDX_W'(g);
    end
  end

  always_comb begin
    grp_bits  = used_map[{grp_sel, GRP_BIT_W'(0)} +: GROUP_W];
    first_bit = '0;
    for (int b = GROUP_W - 1; b >= 0; b--) begin
      if (!grp_bits[b]) first_bit = GRP_BIT_W'(b);
    end
    alloc_idx = {grp_sel, first_bit};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_idx;
    mem_wdata = req_word;
    mem_re    = ctl.exec && (req_cmd == CMD_READ);
    if (ctl.exec && (req_cmd == CMD_WRITE) && in_range) begin
      mem_we = 1'b1;
    end else if (ctl.pick && !none_free) begin
      mem_we    = 1'b1;
      mem_waddr = alloc_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) word_store[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= word_store[req_idx];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd  <= cmd_t'(cmd);
      req_addr <= slot_addr;
      req_word <= word_in;
    end
    if (ctl.exec) begin
      res_slot     <= req_addr;
      res_status   <= 1'b0;
      res_free     <= free_count;
      res_word     <= req_word;
      res_from_mem <= (req_cmd == CMD_READ);
      res_used     <= in_range && used_map[req_idx];
      grp_sel      <= first_grp;
      none_free    <= &group_full;
    end
    if (ctl.pick) begin
      res_from_mem <= 1'b0;
      if (none_free) begin
        res_word   <= '0;
        res_slot   <= '0;
        res_status <= 1'b1;
        res_free   <= free_count;
      end else begin
        res_word   <= req_word;
        res_slot   <= ADDR_W'(alloc_idx);
        res_status <= 1'b0;
        res_free   <= free_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map   <= '0;
      free_count <= CNT_W'(SLOTS);
    end else begin
      if (ctl.exec && (req_cmd == CMD_FREE) && in_range && used_map[req_idx]) begin
        used_map[req_idx] <= 1'b0;
        free_count        <= free_count + CNT_W'(1);
      end
      if (ctl.pick && !none_free) begin
        used_map[alloc_idx] <= 1'b1;
        free_count          <= free_count - CNT_W'(1);
      end
    end
  end

  // A read of a slot that is not allocated answers zero.
  assign word_out   = res_from_mem ? (res_used ? mem_q : '0) : res_word;
  assign slot_out   = res_slot;
  assign status     = res_status;
  assign free_slots = res_free;

endmodule

`default_nettype wire
